>>> design/utcgps_pkg.sv
package utcgps_pkg;

    localparam logic [11:0]        EPOCH_YEAR         = 12'd1980;
    // Leap years in 1..1979
    localparam logic [8:0]         LEAPS_BEFORE_EPOCH = 9'd479;
    localparam logic [4:0]         EPOCH_DAY_SHIFT    = 5'd6;
    // ceil(2^15 / 25): exact quotient for dividends below 1024
    localparam logic [10:0]        RECIP_25           = 11'd1311;
    // ceil(2^16 / 7): exact quotient for dividends below 8192
    localparam logic [13:0]        RECIP_7            = 14'd9363;
    localparam logic [16:0]        SECS_PER_HOUR      = 17'd3600;
    localparam logic [16:0]        SECS_PER_MINUTE    = 17'd60;
    localparam logic signed [20:0] SECS_PER_DAY       = 21'sd86400;
    localparam logic [5:0]         LEAP_SECONDS_RESET = 6'd18;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } utc_req_t;

    typedef struct packed {
        logic [12:0] day_sum;    // days since epoch, valid mod 7
        logic        pre_epoch;  // the first days before the epoch
        logic [4:0]  day;
        logic [16:0] tod;        // time of day plus leap seconds
    } day_stage_t;

    typedef struct packed {
        logic signed [3:0] dow;
        logic [16:0]       tod;
    } dow_stage_t;

    // Days in the months before the given one; months 13 and 14 count as February.
    function automatic logic [8:0] month_offset(input logic [3:0] month, input logic leap);
        logic [8:0] base;
        logic [1:0] extra;
        begin
            base  = 9'd0;
            extra = 2'd0;
            unique case (month)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd0;
                4'd2:    base = 9'd31;
                4'd3:    base = 9'd59;
                4'd4:    base = 9'd90;
                4'd5:    base = 9'd120;
                4'd6:    base = 9'd151;
                4'd7:    base = 9'd181;
                4'd8:    base = 9'd212;
                4'd9:    base = 9'd243;
                4'd10:   base = 9'd273;
                4'd11:   base = 9'd304;
                4'd12:   base = 9'd334;
                4'd13:   base = 9'd365;
                4'd14:   base = 9'd393;
                4'd15:   base = 9'd421;
                default: base = 9'd0;
            endcase
            if (leap)
            begin
                if (month == 4'd15)
                    extra = 2'd3;
                else if (month == 4'd14)
                    extra = 2'd2;
                else if (month >= 4'd3)
                    extra = 2'd1;
            end
            return base + 9'(extra);
        end
    endfunction

endpackage

>>> design/utcgps_day_calc.sv
module utcgps_day_calc
    import utcgps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [5:0] leap_seconds,
    input  logic       up_valid,
    output logic       up_ready,
    input  utc_req_t   up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output day_stage_t dn_data
);

    logic        valid_reg;
    day_stage_t  data_reg;
    day_stage_t  data_next;

    logic [11:0] prev_year;
    logic [20:0] prev_q100_prod;
    logic [18:0] prev_q400_prod;
    logic [20:0] cur_q100_prod;
    logic [18:0] cur_q400_prod;
    logic [5:0]  prev_div100;
    logic [3:0]  prev_div400;
    logic        cur_div100;
    logic        cur_div400;
    logic        leap;
    logic        after_epoch;
    logic [12:0] year_term;

    assign prev_year      = up_data.year - 12'd1;
    assign prev_q100_prod = 21'(prev_year[11:2]) * 21'(RECIP_25);
    assign prev_q400_prod = 19'(prev_year[11:4]) * 19'(RECIP_25);
    assign cur_q100_prod  = 21'(up_data.year[11:2]) * 21'(RECIP_25);
    assign cur_q400_prod  = 19'(up_data.year[11:4]) * 19'(RECIP_25);
    assign prev_div100    = prev_q100_prod[20:15];
    assign prev_div400    = prev_q400_prod[18:15];

    // x is a multiple of 25 exactly when the fraction bits of x*RECIP_25 stay small
    assign cur_div100 = (up_data.year[1:0] == 2'd0) && (cur_q100_prod[14:0] < 15'(RECIP_25));
    assign cur_div400 = (up_data.year[3:0] == 4'd0) && (cur_q400_prod[14:0] < 15'(RECIP_25));
    assign leap       = ((up_data.year[1:0] == 2'd0) && !cur_div100) || cur_div400;

    assign after_epoch = up_data.year > EPOCH_YEAR;

    // 365 is 1 mod 7, so whole years add one day each plus their leap days
    always_comb
    begin
        year_term = 13'd0;
        if (after_epoch)
            year_term = 13'(up_data.year - EPOCH_YEAR) + 13'(prev_year[11:2])
                      + 13'(prev_div400) - 13'(prev_div100) - 13'(LEAPS_BEFORE_EPOCH);
    end

    always_comb
    begin
        data_next.day_sum   = year_term + 13'(month_offset(up_data.month, leap))
                            + 13'(up_data.day) + 13'd1;
        data_next.pre_epoch = !after_epoch && (up_data.month <= 4'd1)
                            && (up_data.day < EPOCH_DAY_SHIFT);
        data_next.day       = up_data.day;
        data_next.tod       = 17'(up_data.hour) * SECS_PER_HOUR
                            + 17'(up_data.minute) * SECS_PER_MINUTE
                            + 17'(up_data.second) + 17'(leap_seconds);
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    // smallest regular sum: year 1981 with month and day zero gives 2 + 1
    a_day_sum_floor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.pre_epoch |-> data_reg.day_sum >= 13'd3)
        else $error("day count below floor on regular path");

endmodule

>>> design/utcgps_weekday.sv
module utcgps_weekday
    import utcgps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  day_stage_t up_data,
    output logic       dn_valid,
    input  logic       dn_ready,
    output dow_stage_t dn_data
);

    logic        valid_reg;
    dow_stage_t  data_reg;
    dow_stage_t  data_next;
    logic [26:0] quot_prod;
    logic [2:0]  rem7;

    assign quot_prod = 27'(up_data.day_sum) * 27'(RECIP_7);
    // remainder = n - 7q; only the low three bits matter and -7q == q mod 8
    assign rem7 = up_data.day_sum[2:0] + quot_prod[18:16];

    always_comb
    begin
        data_next.tod = up_data.tod;
        if (up_data.pre_epoch)
            data_next.dow = $signed(4'(up_data.day) - 4'(EPOCH_DAY_SHIFT));
        else
            data_next.dow = $signed({1'b0, rem7});
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    a_dow_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (data_reg.dow >= -4'sd6) && (data_reg.dow <= 4'sd6))
        else $error("day of week out of range");

endmodule

>>> design/utcgps_result.sv
module utcgps_result
    import utcgps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  dow_stage_t         up_data,
    output logic               dn_valid,
    input  logic               dn_ready,
    output logic signed [20:0] dn_data
);

    logic               valid_reg;
    logic signed [20:0] sow_reg;
    logic signed [20:0] sow_next;
    logic signed [20:0] dow_ext;

    assign dow_ext  = 21'(up_data.dow);
    assign sow_next = dow_ext * SECS_PER_DAY + $signed({4'b0, up_data.tod});

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = sow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            sow_reg <= sow_next;
    end

    a_sow_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (sow_reg >= -21'sd518400) && (sow_reg <= 21'sd633906))
        else $error("seconds of week out of range");

endmodule

>>> design/utc_to_gps_seconds_of_week.sv
// UTC calendar date/time to GPS seconds of week.
//
// Request channel: utc_valid/utc_ready with the date and time fields.
// Result channel: sow_valid/sow_ready with seconds_of_week (signed, negative
// for the last days before 6 Jan 1980). Both accept on valid & ready.
// cfg_wr_en/cfg_wr_data write the leap second offset register.
//
// Four register stages: input, day count, weekday (mod 7), result. A request
// passes through them in that order. One request per cycle is sustained while
// sow_ready is high; each stage only multiplies by constants.
//
// Reset empties all stages and loads a leap second offset of 18.
// When sow_ready is low the result holds and the stages behind it keep
// filling; utc_ready drops only once all four registers are occupied.
module utc_to_gps_seconds_of_week
    import utcgps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [5:0]         cfg_wr_data,
    input  logic               utc_valid,
    output logic               utc_ready,
    input  logic [11:0]        utc_year,
    input  logic [3:0]         utc_month,
    input  logic [4:0]         utc_day,
    input  logic [4:0]         utc_hour,
    input  logic [5:0]         utc_minute,
    input  logic [5:0]         utc_second,
    output logic               sow_valid,
    input  logic               sow_ready,
    output logic signed [20:0] seconds_of_week
);

    logic       leap_seconds_reg;
    logic [5:0] leap_seconds_q_reg;
    logic       req_valid_reg;
    utc_req_t   req_reg;
    utc_req_t   req_next;

    logic       day_ready;
    logic       day_valid;
    day_stage_t day_data;
    logic       dow_ready;
    logic       dow_valid;
    dow_stage_t dow_data;
    logic       res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leap_seconds_reg   <= 1'b0;
            leap_seconds_q_reg <= LEAP_SECONDS_RESET;
        end
        else if (cfg_wr_en)
        begin
            leap_seconds_reg   <= 1'b1;
            leap_seconds_q_reg <= cfg_wr_data;
        end
    end

    assign req_next = '{year: utc_year, month: utc_month, day: utc_day,
                        hour: utc_hour, minute: utc_minute, second: utc_second};

    assign utc_ready = !req_valid_reg || day_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (utc_ready)
            req_valid_reg <= utc_valid;
    end

    always_ff @(posedge clk)
    begin
        if (utc_valid && utc_ready)
            req_reg <= req_next;
    end

    utcgps_day_calc u_day_calc (
        .clk          (clk),
        .rst_n        (rst_n),
        .leap_seconds (leap_seconds_q_reg),
        .up_valid     (req_valid_reg),
        .up_ready     (day_ready),
        .up_data      (req_reg),
        .dn_valid     (day_valid),
        .dn_ready     (dow_ready),
        .dn_data      (day_data)
    );

    utcgps_weekday u_weekday (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (day_valid),
        .up_ready (dow_ready),
        .up_data  (day_data),
        .dn_valid (dow_valid),
        .dn_ready (res_ready),
        .dn_data  (dow_data)
    );

    utcgps_result u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (dow_valid),
        .up_ready (res_ready),
        .up_data  (dow_data),
        .dn_valid (sow_valid),
        .dn_ready (sow_ready),
        .dn_data  (seconds_of_week)
    );

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> leap_seconds_q_reg == $past(cfg_wr_data))
        else $error("leap second register did not take the write");

    a_reset_offset: assert property (@(posedge clk) disable iff (!rst_n)
        !leap_seconds_reg |-> leap_seconds_q_reg == LEAP_SECONDS_RESET)
        else $error("leap second offset changed without a write");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !utc_ready |-> req_valid_reg && day_valid && dow_valid && sow_valid && !sow_ready)
        else $error("request stalled while a stage is empty");

endmodule
